// File: rtl/haptic_count_pulse_sequencer_unit_assert.svh
// Assertion macros shared by the sequencer RTL.
`ifndef HAPTIC_COUNT_PULSE_SEQUENCER_UNIT_ASSERT_SVH
`define HAPTIC_COUNT_PULSE_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HCPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/hcps_pkg.sv
package hcps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int PW_W   = 12;
  localparam int PER_W  = 16;
  localparam int DUR_W  = 20;
  localparam int ELAP_W = 21;

  localparam logic [PW_W-1:0]  PW_FIRST_RST  = 12'd1000;
  localparam logic [PW_W-1:0]  PW_SECOND_RST = 12'd1200;
  localparam logic [PER_W-1:0] PERIOD_RST    = 16'd20000;
  localparam logic [DUR_W-1:0] BUZZ_RST      = 20'd250000;
  localparam logic [DUR_W-1:0] LAST_BUZZ_RST = 20'd500000;
  localparam logic [DUR_W-1:0] LONG_BUZZ_RST = 20'd1000000;
  localparam logic [DUR_W-1:0] GAP_RST       = 20'd166666;
  localparam logic [DUR_W-1:0] LONG_GAP_RST  = 20'd1000000;

  typedef enum logic [2:0] {
    REG_PW_FIRST  = 3'd0,
    REG_PW_SECOND = 3'd1,
    REG_PERIOD    = 3'd2,
    REG_BUZZ      = 3'd3,
    REG_LAST_BUZZ = 3'd4,
    REG_LONG_BUZZ = 3'd5,
    REG_GAP       = 3'd6,
    REG_LONG_GAP  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEG_IDLE     = 3'd0,
    SEG_BUZZ     = 3'd1,
    SEG_LAST     = 3'd2,
    SEG_LONG     = 3'd3,
    SEG_GAP      = 3'd4,
    SEG_LONG_GAP = 3'd5
  } seg_t;

  typedef enum logic [2:0] {
    PH_NONE      = 3'd0,
    PH_SIGN_GAP  = 3'd1,
    PH_FIRST     = 3'd2,
    PH_UNIT_GAP  = 3'd3,
    PH_UNIT_BUZZ = 3'd4,
    PH_CLOSE     = 3'd5
  } phase_t;

endpackage

// File: rtl/haptic_count_pulse_sequencer_unit.sv
// Output register: a result appears there in the cycle after its input transfer.
// Throughput: one item per cycle; the input is ready whenever the output register is
// empty or its result is taken in the same cycle, so only a stalled output holds it.
// Reset (synchronous, rst_n low): queue empty, idle segment, pulse timer zero, and all
// configuration registers back to their default durations and widths.
`include "haptic_count_pulse_sequencer_unit_assert.svh"

module haptic_count_pulse_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [3:0] count (signed), [7:4] zero
  input  logic                              in_tuser,   // [0] action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] servo_level, [3:1] segment_kind, [4] dropped, [9:5] queued, [15:10] zero
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [hcps_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [hcps_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [hcps_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DEPTH  = hcps_pkg::QUEUE_DEPTH;
  localparam int IDX_W  = hcps_pkg::IDX_W;
  localparam int FILL_W = hcps_pkg::FILL_W;
  localparam int SUM_W  = FILL_W + 1;
  localparam int PW_W   = hcps_pkg::PW_W;
  localparam int PER_W  = hcps_pkg::PER_W;
  localparam int DUR_W  = hcps_pkg::DUR_W;
  localparam int ELAP_W = hcps_pkg::ELAP_W;
  localparam int DW     = hcps_pkg::CFG_DATA_W;

  // Configuration registers.
  logic [PW_W-1:0]  pw_first_r, pw_second_r;
  logic [PER_W-1:0] period_r;
  logic [DUR_W-1:0] buzz_r, last_buzz_r, long_buzz_r, gap_r, long_gap_r;

  logic            cfg_wr;
  hcps_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = hcps_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_first_r  <= hcps_pkg::PW_FIRST_RST;
      pw_second_r <= hcps_pkg::PW_SECOND_RST;
      period_r    <= hcps_pkg::PERIOD_RST;
      buzz_r      <= hcps_pkg::BUZZ_RST;
      last_buzz_r <= hcps_pkg::LAST_BUZZ_RST;
      long_buzz_r <= hcps_pkg::LONG_BUZZ_RST;
      gap_r       <= hcps_pkg::GAP_RST;
      long_gap_r  <= hcps_pkg::LONG_GAP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hcps_pkg::REG_PW_FIRST:  pw_first_r  <= cfg_pwdata[PW_W-1:0];
        hcps_pkg::REG_PW_SECOND: pw_second_r <= cfg_pwdata[PW_W-1:0];
        hcps_pkg::REG_PERIOD:    period_r    <= cfg_pwdata[PER_W-1:0];
        hcps_pkg::REG_BUZZ:      buzz_r      <= cfg_pwdata[DUR_W-1:0];
        hcps_pkg::REG_LAST_BUZZ: last_buzz_r <= cfg_pwdata[DUR_W-1:0];
        hcps_pkg::REG_LONG_BUZZ: long_buzz_r <= cfg_pwdata[DUR_W-1:0];
        hcps_pkg::REG_GAP:       gap_r       <= cfg_pwdata[DUR_W-1:0];
        hcps_pkg::REG_LONG_GAP:  long_gap_r  <= cfg_pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hcps_pkg::REG_PW_FIRST:  cfg_prdata = DW'(pw_first_r);
      hcps_pkg::REG_PW_SECOND: cfg_prdata = DW'(pw_second_r);
      hcps_pkg::REG_PERIOD:    cfg_prdata = DW'(period_r);
      hcps_pkg::REG_BUZZ:      cfg_prdata = DW'(buzz_r);
      hcps_pkg::REG_LAST_BUZZ: cfg_prdata = DW'(last_buzz_r);
      hcps_pkg::REG_LONG_BUZZ: cfg_prdata = DW'(long_buzz_r);
      hcps_pkg::REG_GAP:       cfg_prdata = DW'(gap_r);
      hcps_pkg::REG_LONG_GAP:  cfg_prdata = DW'(long_gap_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Sequencer state.
  logic [3:0]         queue_r [DEPTH];
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  hcps_pkg::seg_t     seg_r, seg_nxt;
  hcps_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]         units_r, units_nxt;
  logic [ELAP_W-1:0]  elapsed_r, elapsed_nxt;
  logic [PER_W-1:0]   wait_r, wait_nxt;
  logic [PW_W-1:0]    high_r, high_nxt;
  logic               swapped_r, swapped_nxt;

  // Output register.
  logic               out_valid_r;
  logic               out_level_r, out_level_nxt;
  hcps_pkg::seg_t     out_kind_r, out_kind_nxt;
  logic               out_dropped_r, out_dropped_nxt;
  logic [FILL_W-1:0]  out_queued_r;

  logic               in_fire;
  logic               q_we;
  logic [SUM_W-1:0]   tail_sum;
  logic [IDX_W-1:0]   tail_idx;
  logic [3:0]         raw;
  logic [3:0]         neg_mag;
  logic [2:0]         units_dec;
  logic [PW_W-1:0]    width_sel;
  logic [DUR_W-1:0]   dur;
  logic               buzzing;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign tail_sum = SUM_W'(head_r) + SUM_W'(fill_r);
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);
  assign raw      = queue_r[head_r];
  assign neg_mag  = 4'd0 - raw;
  assign units_dec = (units_r != 3'd0) ? units_r - 3'd1 : 3'd0;
  assign width_sel = swapped_r ? pw_second_r : pw_first_r;

  always_comb begin
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    seg_nxt         = seg_r;
    phase_nxt       = phase_r;
    units_nxt       = units_r;
    elapsed_nxt     = elapsed_r;
    wait_nxt        = wait_r;
    high_nxt        = high_r;
    swapped_nxt     = swapped_r;
    q_we            = 1'b0;
    out_level_nxt   = 1'b0;
    out_kind_nxt    = seg_r;
    out_dropped_nxt = 1'b0;
    dur             = '0;
    buzzing         = 1'b0;

    if (in_fire && in_tuser) begin
      // Enqueue: time stands still, the pin shows a pulse still in progress.
      if (fill_r == FILL_W'(DEPTH)) begin
        out_dropped_nxt = 1'b1;
      end else begin
        q_we     = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
      out_level_nxt = (high_r != '0);
    end else if (in_fire) begin
      if (seg_r == hcps_pkg::SEG_IDLE) begin
        case (phase_r)
          hcps_pkg::PH_NONE: begin
            if (fill_r != '0) begin
              head_nxt    = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
              fill_nxt    = fill_r - 1'b1;
              elapsed_nxt = '0;
              if (raw[3]) begin
                // Minus eight saturates to a magnitude of seven.
                units_nxt = neg_mag[3] ? 3'd7 : neg_mag[2:0];
                seg_nxt   = hcps_pkg::SEG_LONG;
                phase_nxt = hcps_pkg::PH_SIGN_GAP;
              end else begin
                units_nxt = raw[2:0];
                seg_nxt   = hcps_pkg::SEG_BUZZ;
                phase_nxt = (raw[2:0] != 3'd0) ? hcps_pkg::PH_UNIT_GAP : hcps_pkg::PH_CLOSE;
              end
            end
          end
          hcps_pkg::PH_SIGN_GAP: begin
            seg_nxt     = hcps_pkg::SEG_GAP;
            phase_nxt   = hcps_pkg::PH_FIRST;
            elapsed_nxt = '0;
          end
          hcps_pkg::PH_FIRST: begin
            seg_nxt     = hcps_pkg::SEG_BUZZ;
            phase_nxt   = (units_r != 3'd0) ? hcps_pkg::PH_UNIT_GAP : hcps_pkg::PH_CLOSE;
            elapsed_nxt = '0;
          end
          hcps_pkg::PH_UNIT_GAP: begin
            seg_nxt     = hcps_pkg::SEG_GAP;
            phase_nxt   = hcps_pkg::PH_UNIT_BUZZ;
            elapsed_nxt = '0;
          end
          hcps_pkg::PH_UNIT_BUZZ: begin
            units_nxt   = units_dec;
            seg_nxt     = (units_dec != 3'd0) ? hcps_pkg::SEG_BUZZ : hcps_pkg::SEG_LAST;
            phase_nxt   = (units_dec != 3'd0) ? hcps_pkg::PH_UNIT_GAP : hcps_pkg::PH_CLOSE;
            elapsed_nxt = '0;
          end
          default: begin
            seg_nxt     = hcps_pkg::SEG_LONG_GAP;
            phase_nxt   = hcps_pkg::PH_NONE;
            elapsed_nxt = '0;
          end
        endcase
      end
      out_kind_nxt = seg_nxt;

      buzzing = (seg_nxt == hcps_pkg::SEG_BUZZ) || (seg_nxt == hcps_pkg::SEG_LAST) ||
                (seg_nxt == hcps_pkg::SEG_LONG);
      if (high_r != '0) begin
        out_level_nxt = 1'b1;
        high_nxt      = high_r - 1'b1;
      end else if (buzzing && wait_r == '0) begin
        // A zero width pulse still counts as started and still swaps the widths.
        if (width_sel != '0) begin
          out_level_nxt = 1'b1;
          high_nxt      = width_sel - 1'b1;
        end
        wait_nxt    = (period_r > PER_W'(width_sel)) ? period_r - PER_W'(width_sel) : '0;
        swapped_nxt = !swapped_r;
      end else if (wait_r != '0) begin
        wait_nxt = wait_r - 1'b1;
      end

      case (seg_nxt)
        hcps_pkg::SEG_BUZZ:     dur = buzz_r;
        hcps_pkg::SEG_LAST:     dur = last_buzz_r;
        hcps_pkg::SEG_LONG:     dur = long_buzz_r;
        hcps_pkg::SEG_GAP:      dur = gap_r;
        hcps_pkg::SEG_LONG_GAP: dur = long_gap_r;
        default:                dur = '0;
      endcase
      if (seg_nxt != hcps_pkg::SEG_IDLE) begin
        if (elapsed_nxt >= ELAP_W'(dur)) begin
          seg_nxt     = hcps_pkg::SEG_IDLE;
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = elapsed_nxt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_r[tail_idx] <= in_tdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      seg_r       <= hcps_pkg::SEG_IDLE;
      phase_r     <= hcps_pkg::PH_NONE;
      units_r     <= '0;
      elapsed_r   <= '0;
      wait_r      <= '0;
      high_r      <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      seg_r     <= seg_nxt;
      phase_r   <= phase_nxt;
      units_r   <= units_nxt;
      elapsed_r <= elapsed_nxt;
      wait_r    <= wait_nxt;
      high_r    <= high_nxt;
      swapped_r <= swapped_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_level_r   <= out_level_nxt;
      out_kind_r    <= out_kind_nxt;
      out_dropped_r <= out_dropped_nxt;
      out_queued_r  <= fill_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, 5'(out_queued_r), out_dropped_r, out_kind_r, out_level_r};

  `HCPS_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(DEPTH), "queue fill above depth")
  `HCPS_ASSERT(a_drop_when_full, clk, rst_n, (in_fire && in_tuser && fill_r == FILL_W'(DEPTH)) |=> (out_valid_r && out_dropped_r), "full queue enqueue not flagged")
  `HCPS_ASSERT(a_pulse_holds_pin, clk, rst_n, (in_fire && !in_tuser && high_r != '0) |=> out_level_r, "pin low while a pulse is running")
  `HCPS_ASSERT(a_idle_elapsed_zero, clk, rst_n, (seg_r == hcps_pkg::SEG_IDLE) |-> (elapsed_r == '0), "elapsed time nonzero while idle")

endmodule

// File: tb/haptic_count_pulse_sequencer_unit_tb.sv
module haptic_count_pulse_sequencer_unit_tb;

  localparam int QUIET_LIMIT = 4000;

  localparam int QUEUE_DEPTH = hcps_pkg::QUEUE_DEPTH;
  localparam int IDX_W       = hcps_pkg::IDX_W;
  localparam int FILL_W      = hcps_pkg::FILL_W;
  localparam int ELAP_W      = hcps_pkg::ELAP_W;
  localparam int PER_W       = hcps_pkg::PER_W;
  localparam int PW_W        = hcps_pkg::PW_W;
  localparam int CFG_ADDR_W  = hcps_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = hcps_pkg::CFG_DATA_W;

  typedef struct packed {
    logic           level;
    hcps_pkg::seg_t kind;
    logic           dropped;
    logic [4:0]     queued;
  } servo_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [3:0] count (signed), [7:4] zero
  logic                  in_tuser = 1'b0; // [0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] servo_level, [3:1] segment_kind, [4] dropped, [9:5] queued, [15:10] zero
  logic [15:0]           out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  haptic_count_pulse_sequencer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the block: registers, count queue and playback state.
  logic [31:0]       reg_shadow [8];
  logic [3:0]        count_store [QUEUE_DEPTH];
  logic [IDX_W-1:0]  q_head;
  logic [FILL_W-1:0] q_fill;
  hcps_pkg::seg_t    cur_seg;
  hcps_pkg::phase_t  cur_phase;
  logic [2:0]        units_todo;
  logic [ELAP_W-1:0] seg_ticks;
  logic [PER_W-1:0]  pulse_gap;
  logic [PW_W-1:0]   pulse_left;
  logic              widths_flip;

  servo_out_t predicted_outputs [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;

  function automatic logic [31:0] reg_mask(hcps_pkg::reg_idx_t idx);
    case (idx)
      hcps_pkg::REG_PW_FIRST, hcps_pkg::REG_PW_SECOND: return 32'h0000_0FFF;
      hcps_pkg::REG_PERIOD:                            return 32'h0000_FFFF;
      default:                                         return 32'h000F_FFFF;
    endcase
  endfunction

  function automatic void reset_shadow();
    reg_shadow[hcps_pkg::REG_PW_FIRST]  = 32'(hcps_pkg::PW_FIRST_RST);
    reg_shadow[hcps_pkg::REG_PW_SECOND] = 32'(hcps_pkg::PW_SECOND_RST);
    reg_shadow[hcps_pkg::REG_PERIOD]    = 32'(hcps_pkg::PERIOD_RST);
    reg_shadow[hcps_pkg::REG_BUZZ]      = 32'(hcps_pkg::BUZZ_RST);
    reg_shadow[hcps_pkg::REG_LAST_BUZZ] = 32'(hcps_pkg::LAST_BUZZ_RST);
    reg_shadow[hcps_pkg::REG_LONG_BUZZ] = 32'(hcps_pkg::LONG_BUZZ_RST);
    reg_shadow[hcps_pkg::REG_GAP]       = 32'(hcps_pkg::GAP_RST);
    reg_shadow[hcps_pkg::REG_LONG_GAP]  = 32'(hcps_pkg::LONG_GAP_RST);
    q_head      = '0;
    q_fill      = '0;
    cur_seg     = hcps_pkg::SEG_IDLE;
    cur_phase   = hcps_pkg::PH_NONE;
    units_todo  = '0;
    seg_ticks   = '0;
    pulse_gap   = '0;
    pulse_left  = '0;
    widths_flip = 1'b0;
  endfunction

  function automatic int seg_length(hcps_pkg::seg_t kind);
    case (kind)
      hcps_pkg::SEG_BUZZ:     return int'(reg_shadow[hcps_pkg::REG_BUZZ]);
      hcps_pkg::SEG_LAST:     return int'(reg_shadow[hcps_pkg::REG_LAST_BUZZ]);
      hcps_pkg::SEG_LONG:     return int'(reg_shadow[hcps_pkg::REG_LONG_BUZZ]);
      hcps_pkg::SEG_GAP:      return int'(reg_shadow[hcps_pkg::REG_GAP]);
      hcps_pkg::SEG_LONG_GAP: return int'(reg_shadow[hcps_pkg::REG_LONG_GAP]);
      default:                return 0;
    endcase
  endfunction

  function automatic void enter_seg(hcps_pkg::seg_t kind, hcps_pkg::phase_t after);
    cur_seg   = kind;
    cur_phase = after;
    seg_ticks = '0;
  endfunction

  function automatic void open_next_segment();
    logic [3:0] raw;
    int mag;
    case (cur_phase)
      hcps_pkg::PH_NONE: begin
        if (q_fill != 0) begin
          raw    = count_store[q_head];
          q_head = IDX_W'((int'(q_head) + 1) % QUEUE_DEPTH);
          q_fill = q_fill - 1'b1;
          if (raw[3]) begin
            // Minus eight has no positive twin and saturates to seven units.
            mag = 16 - int'(raw);
            if (mag > 7) mag = 7;
            units_todo = 3'(mag);
            enter_seg(hcps_pkg::SEG_LONG, hcps_pkg::PH_SIGN_GAP);
          end else begin
            units_todo = raw[2:0];
            enter_seg(hcps_pkg::SEG_BUZZ,
                      (raw != 0) ? hcps_pkg::PH_UNIT_GAP : hcps_pkg::PH_CLOSE);
          end
        end
      end
      hcps_pkg::PH_SIGN_GAP: enter_seg(hcps_pkg::SEG_GAP, hcps_pkg::PH_FIRST);
      hcps_pkg::PH_FIRST:
        enter_seg(hcps_pkg::SEG_BUZZ,
                  (units_todo != 0) ? hcps_pkg::PH_UNIT_GAP : hcps_pkg::PH_CLOSE);
      hcps_pkg::PH_UNIT_GAP: enter_seg(hcps_pkg::SEG_GAP, hcps_pkg::PH_UNIT_BUZZ);
      hcps_pkg::PH_UNIT_BUZZ: begin
        if (units_todo != 0) units_todo = units_todo - 1'b1;
        if (units_todo != 0) enter_seg(hcps_pkg::SEG_BUZZ, hcps_pkg::PH_UNIT_GAP);
        else enter_seg(hcps_pkg::SEG_LAST, hcps_pkg::PH_CLOSE);
      end
      default: enter_seg(hcps_pkg::SEG_LONG_GAP, hcps_pkg::PH_NONE);
    endcase
  endfunction

  function automatic servo_out_t sequence_item(logic action, logic [3:0] count);
    servo_out_t r;
    int w;
    int per;
    r = '0;
    if (action) begin
      if (int'(q_fill) >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        count_store[IDX_W'((int'(q_head) + int'(q_fill)) % QUEUE_DEPTH)] = count;
        q_fill = q_fill + 1'b1;
      end
      r.level = (pulse_left != 0);
      r.kind  = cur_seg;
    end else begin
      if (cur_seg == hcps_pkg::SEG_IDLE) open_next_segment();
      r.kind = cur_seg;
      if (pulse_left != 0) begin
        r.level    = 1'b1;
        pulse_left = pulse_left - 1'b1;
      end else if ((cur_seg == hcps_pkg::SEG_BUZZ || cur_seg == hcps_pkg::SEG_LAST ||
                    cur_seg == hcps_pkg::SEG_LONG) && pulse_gap == 0) begin
        w   = widths_flip ? int'(reg_shadow[hcps_pkg::REG_PW_SECOND])
                          : int'(reg_shadow[hcps_pkg::REG_PW_FIRST]);
        per = int'(reg_shadow[hcps_pkg::REG_PERIOD]);
        // A zero width pulse still counts as started and still swaps the widths.
        if (w > 0) begin
          r.level    = 1'b1;
          pulse_left = PW_W'(w - 1);
        end
        pulse_gap   = (per > w) ? PER_W'(per - w) : '0;
        widths_flip = ~widths_flip;
      end else if (pulse_gap != 0) begin
        pulse_gap = pulse_gap - 1'b1;
      end
      if (cur_seg != hcps_pkg::SEG_IDLE) begin
        if (int'(seg_ticks) >= seg_length(cur_seg)) begin
          cur_seg   = hcps_pkg::SEG_IDLE;
          seg_ticks = '0;
        end else begin
          seg_ticks = seg_ticks + 1'b1;
        end
      end
    end
    r.queued = 5'(q_fill);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker and predictor share one process, so a transfer on the result
  // side is matched before the input transfer of the same edge is predicted.
  always @(posedge clk) begin
    servo_out_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (predicted_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          check_field("servo_level", want.level, out_tdata[0]);
          check_field("segment_kind", want.kind, out_tdata[3:1]);
          check_field("dropped", want.dropped, out_tdata[4]);
          check_field("queued", want.queued, out_tdata[9:5]);
        end
      end
      if (in_tvalid && in_tready)
        predicted_outputs.push_back(sequence_item(in_tuser, in_tdata[3:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stalls follow a randomly drawn mode, drawn again whenever ready_count[5:0] is zero.
  int       ready_count = 0;
  bit [1:0] ready_mode = 2'd0;
  always @(posedge clk) begin
    ready_count <= ready_count + 1;
    if (ready_count[5:0] == 0) ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ready_count[2];
    endcase
  end

  task automatic send_item(logic action, logic [3:0] count);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {4'b0000, count};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (predicted_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic write, hcps_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (write) begin
      reg_shadow[idx] = value & reg_mask(idx);
    end else if (cfg_prdata !== reg_shadow[idx]) begin
      $display("%0t: register %s readback, expected %h, actual %h", $time, idx.name(),
               reg_shadow[idx], cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [31:0] w1, logic [31:0] w2, logic [31:0] per,
                            logic [31:0] buzz, logic [31:0] last, logic [31:0] lng,
                            logic [31:0] gap, logic [31:0] lgap);
    apb_access(1'b1, hcps_pkg::REG_PW_FIRST, w1);
    apb_access(1'b1, hcps_pkg::REG_PW_SECOND, w2);
    apb_access(1'b1, hcps_pkg::REG_PERIOD, per);
    apb_access(1'b1, hcps_pkg::REG_BUZZ, buzz);
    apb_access(1'b1, hcps_pkg::REG_LAST_BUZZ, last);
    apb_access(1'b1, hcps_pkg::REG_LONG_BUZZ, lng);
    apb_access(1'b1, hcps_pkg::REG_GAP, gap);
    apb_access(1'b1, hcps_pkg::REG_LONG_GAP, lgap);
    for (int i = 0; i < 8; i++) apb_access(1'b0, hcps_pkg::reg_idx_t'(i), '0);
  endtask

  task automatic random_items(int n, int enq_odds);
    for (int i = 0; i < n; i++)
      send_item($urandom_range(0, enq_odds) == 0, 4'($urandom()));
  endtask

  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) apb_access(1'b0, hcps_pkg::reg_idx_t'(i), '0);
  endtask

  // Zero count, both ends of the count range, and a full queue that drops the next count.
  task automatic test_directed_patterns();
    set_timing(2, 3, 4, 1, 2, 3, 1, 2);
    send_item(1'b0, 4'hF);
    send_item(1'b1, 4'd0);
    repeat (3) send_item(1'b0, 4'h0);
    send_item(1'b1, 4'b1000);
    send_item(1'b1, 4'd7);
    send_item(1'b1, 4'b1111);
    repeat (14) send_item(1'b1, 4'($urandom()));
    repeat (3) send_item(1'b0, 4'($urandom()));
    wait_drain();
  endtask

  task automatic test_random_settings();
    set_timing(3, 5, 10, 4, 6, 8, 3, 5);
    random_items(220, 16);
    wait_drain();
    // Zero width pulses next to a short period.
    set_timing(0, 2, 3, 0, 1, 2, 0, 1);
    random_items(220, 8);
    wait_drain();
    // The first width lies above the period and leaves no wait after its pulses.
    set_timing(7, 4, 5, $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
               $urandom_range(0, 12), $urandom_range(0, 12));
    random_items(220, 12);
    wait_drain();
    // Everything at zero, with heavy enqueueing so the queue fills and drops.
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    random_items(220, 2);
    wait_drain();
    for (int k = 0; k < 2; k++) begin
      set_timing($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
                 $urandom_range(0, 20), $urandom_range(0, 20));
      random_items(220, (k == 0) ? 6 : 20);
      wait_drain();
    end
  endtask

  task automatic test_register_extremes();
    set_timing('1, '1, '1, '1, '1, '1, '1, '1);
    send_item(1'b1, 4'b1000);
    send_item(1'b1, 4'd7);
    repeat (20) send_item(1'b0, 4'($urandom()));
    send_item(1'b1, 4'd5);
    repeat (6) send_item(1'b0, 4'($urandom()));
    wait_drain();
  endtask

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed_patterns();
    test_random_settings();
    test_register_extremes();
    repeat (4) @(posedge clk);
    if (predicted_outputs.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               predicted_outputs.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
